// ===== rtl/fmprc_pkg.sv =====
// shared types, constants and helpers for the packet rule classifier
package fmprc_pkg;

    localparam int STORE_DEPTH        = 512;
    localparam int ADDR_W             = 9;
    localparam int WORD_W             = 64;
    localparam int ID_W               = 8;
    localparam int DEF_RULE_COUNT     = 64;
    localparam int DEF_WORDS_PER_RULE = 8;
    localparam int ETH_HDR_LEN        = 14;
    localparam int RULE_SPAN          = 7;

    typedef enum logic {
        OP_CLASSIFY = 1'b0,
        OP_WRITE    = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        PC_NONE    = 3'd0,
        PC_V4_TCP  = 3'd1,
        PC_V4_UDP  = 3'd2,
        PC_V4_ICMP = 3'd3,
        PC_V6_TCP  = 3'd4,
        PC_V6_UDP  = 3'd5,
        PC_V6_ICMP = 3'd6,
        PC_BAD     = 3'd7
    } t_pclass;

    // order in which the words of one rule are fetched
    typedef enum logic [2:0] {
        STEP_W5, STEP_W6, STEP_W0, STEP_W1, STEP_W2, STEP_W3, STEP_W4
    } t_step;

    typedef enum logic [1:0] {
        ST_CLEAR, ST_IDLE, ST_SCAN, ST_DONE
    } t_state;

    typedef struct packed {
        t_pclass     pclass;
        logic [63:0] src_hi;
        logic [63:0] src_lo;
        logic [63:0] dst_hi;
        logic [63:0] dst_lo;
        logic [15:0] ttl_tos;
        logic [15:0] hlen;
        logic [31:0] l4;
        logic [7:0]  flags;
    } t_pkt;

    typedef struct packed {
        logic  valid;
        t_step step;
    } t_match_ctl;

    function automatic logic [2:0] step_word(t_step s);
        logic [2:0] w;
        unique case (s)
            STEP_W5: w = 3'd5;
            STEP_W6: w = 3'd6;
            STEP_W0: w = 3'd0;
            STEP_W1: w = 3'd1;
            STEP_W2: w = 3'd2;
            STEP_W3: w = 3'd3;
            STEP_W4: w = 3'd4;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/first_match_packet_rule_classifier.sv =====
// First-match packet rule classifier. After reset the rule memory is swept to zero, with
// s_axis_tready low. A rule word write (tuser 1) is written to the memory when it is accepted
// and gives no result. A classify item (tuser 0) scans the rules in order, fetching one 64-bit
// word per cycle within a rule from the rule memory's registered read port: a rule whose id is
// zero ends the scan, and a disabled rule or one that fails a test is left for the next one.
// The result waits until the previous result has been taken.
// Unsupported protocol classes are answered without a scan.
module first_match_packet_rule_classifier
    import fmprc_pkg::*;
#(
    parameter int RULE_COUNT     = DEF_RULE_COUNT,
    parameter int WORDS_PER_RULE = DEF_WORDS_PER_RULE
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // protocol_class, src_addr_hi, src_addr_lo, dst_addr_hi, dst_addr_lo, ttl_and_tos,
    // header_length, l4_info, tcp_flags, rule_address, rule_word, zero pad
    input  logic [407:0] s_axis_tdata,
    // op
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // drop, matched, matched_id, zero pad
    output logic [15:0]  m_axis_tdata
);

    localparam int BASE_W = $clog2(RULE_COUNT * WORDS_PER_RULE + 1);
    localparam int RULE_W = $clog2(RULE_COUNT + 1);
    localparam int SUM_W  = BASE_W + ADDR_W;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_clr;
    logic [RULE_W-1:0] r_rule, n_rule;
    logic [BASE_W-1:0] r_base, n_base;
    t_step             r_step, n_step;
    logic              r_dv, n_dv;
    logic [WORD_W-1:0] r_w5;
    t_pkt              r_pkt;
    logic              r_res_drop, n_res_drop;
    logic              r_res_match, n_res_match;
    logic [ID_W-1:0]   r_res_id, n_res_id;
    logic              r_ovalid;
    logic [15:0]       r_odata;

    logic              s_acc;
    t_op               in_op;
    t_pkt              in_pkt;
    t_step             rd_step;
    logic [SUM_W-1:0]  addr_sum;
    logic [ADDR_W-1:0] rd_addr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] rdata;
    t_match_ctl        mctl;
    logic              pass;
    logic              out_free;
    logic              load_out;

    assign s_acc        = s_axis_tvalid && s_axis_tready;
    assign in_op        = t_op'(s_axis_tuser);
    assign in_pkt       = '{pclass:  t_pclass'(s_axis_tdata[2:0]),
                            src_hi:  s_axis_tdata[66:3],
                            src_lo:  s_axis_tdata[130:67],
                            dst_hi:  s_axis_tdata[194:131],
                            dst_lo:  s_axis_tdata[258:195],
                            ttl_tos: s_axis_tdata[274:259],
                            hlen:    s_axis_tdata[290:275],
                            l4:      s_axis_tdata[322:291],
                            flags:   s_axis_tdata[330:323]};
    assign s_axis_tready = (r_state == ST_IDLE);
    assign out_free      = !r_ovalid || m_axis_tready;

    assign addr_sum = SUM_W'(r_base) + SUM_W'(step_word(rd_step));
    assign rd_addr  = addr_sum[ADDR_W-1:0];

    always_comb begin
        if (r_state == ST_CLEAR) begin
            we    = 1'b1;
            waddr = r_clr;
            wdata = '0;
        end else begin
            we    = s_acc && (in_op == OP_WRITE);
            waddr = s_axis_tdata[339:331];
            wdata = s_axis_tdata[403:340];
        end
    end

    fmprc_store u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    assign mctl.valid = (r_state == ST_SCAN) && r_dv;
    assign mctl.step  = r_step;

    fmprc_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mctl),
        .i_pkt   (r_pkt),
        .i_word  (rdata),
        .i_w5    (r_w5),
        .o_pass  (pass)
    );

    always_comb begin
        n_state     = r_state;
        n_rule      = r_rule;
        n_base      = r_base;
        n_step      = r_step;
        n_dv        = 1'b0;
        n_res_drop  = r_res_drop;
        n_res_match = r_res_match;
        n_res_id    = r_res_id;
        rd_step     = STEP_W5;
        load_out    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(STORE_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_acc && (in_op == OP_CLASSIFY)) begin
                    n_res_drop  = 1'b0;
                    n_res_match = 1'b0;
                    n_res_id    = '0;
                    n_rule      = '0;
                    n_base      = '0;
                    if (in_pkt.pclass == PC_NONE || in_pkt.pclass == PC_BAD) begin
                        n_res_drop = 1'b1;
                        n_state    = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!r_dv) begin
                    // start a rule: its id word comes first
                    if ((r_rule == RULE_W'(RULE_COUNT)) ||
                        (SUM_W'(r_base) + SUM_W'(RULE_SPAN) > SUM_W'(STORE_DEPTH))) begin
                        n_state = ST_DONE;
                    end else begin
                        rd_step = STEP_W5;
                        n_step  = STEP_W5;
                        n_dv    = 1'b1;
                    end
                end else if ((r_step == STEP_W5) && (rdata[15:8] == 8'd0)) begin
                    n_state = ST_DONE;
                end else if (((r_step == STEP_W5) && !rdata[0]) || !pass) begin
                    n_rule = r_rule + RULE_W'(1);
                    n_base = r_base + BASE_W'(WORDS_PER_RULE);
                end else if (r_step == STEP_W4) begin
                    n_res_drop  = !r_w5[7];
                    n_res_match = 1'b1;
                    n_res_id    = r_w5[15:8];
                    n_state     = ST_DONE;
                end else begin
                    rd_step = t_step'(r_step + 3'd1);
                    n_step  = rd_step;
                    n_dv    = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_dv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= n_dv;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + ADDR_W'(1);
            end
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rule      <= n_rule;
        r_base      <= n_base;
        r_step      <= n_step;
        r_res_drop  <= n_res_drop;
        r_res_match <= n_res_match;
        r_res_id    <= n_res_id;
        if (s_acc) begin
            r_pkt <= in_pkt;
        end
        if (mctl.valid && (r_step == STEP_W5)) begin
            r_w5 <= rdata;
        end
        if (load_out) begin
            r_odata <= {6'd0, r_res_id, r_res_match, r_res_drop};
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

// ===== rtl/fmprc_store.sv =====
// rule word memory, one write and one registered read port
module fmprc_store
    import fmprc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [STORE_DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fmprc_match.sv =====
// shared rule test unit, checks one rule word per cycle against the packet
module fmprc_match
    import fmprc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_match_ctl        i_ctl,
    input  t_pkt              i_pkt,
    input  logic [WORD_W-1:0] i_word,
    input  logic [WORD_W-1:0] i_w5,
    output logic              o_pass
);

    logic        r_nz;
    logic        r_eq;
    logic        n_nz;
    logic        n_eq;
    logic        v6;
    logic        is_tcp;
    logic        is_udp;
    logic        is_icmp;
    logic [7:0]  ttl;
    logic [16:0] len;
    logic        sp_ok;
    logic        dp_ok;
    logic        ty_ok;
    logic        co_ok;
    logic        fl_ok;
    logic        l4_ok;
    logic        tos_ok;

    always_comb begin
        v6      = (i_pkt.pclass == PC_V6_TCP) || (i_pkt.pclass == PC_V6_UDP) ||
                  (i_pkt.pclass == PC_V6_ICMP);
        is_tcp  = (i_pkt.pclass == PC_V4_TCP) || (i_pkt.pclass == PC_V6_TCP);
        is_udp  = (i_pkt.pclass == PC_V4_UDP) || (i_pkt.pclass == PC_V6_UDP);
        is_icmp = (i_pkt.pclass == PC_V4_ICMP) || (i_pkt.pclass == PC_V6_ICMP);
        ttl     = i_pkt.ttl_tos[7:0];
        len     = {1'b0, i_pkt.hlen} + 17'(ETH_HDR_LEN);
        sp_ok   = !i_word[3] || (i_pkt.l4[31:16] == i_word[39:24]);
        dp_ok   = !i_word[4] || (i_pkt.l4[15:0] == i_word[55:40]);
        ty_ok   = !i_word[3] || (i_pkt.l4[15:8] == i_word[31:24]);
        co_ok   = !i_word[4] || (i_pkt.l4[7:0] == i_word[47:40]);
        fl_ok   = ((i_pkt.flags ^ i_word[23:16]) & i_word[15:8]) == 8'd0;
        tos_ok  = v6 || !i_w5[5] || (i_pkt.ttl_tos[15:8] == i_word[63:56]);
        priority if (i_word[0]) begin
            l4_ok = is_tcp && sp_ok && dp_ok && fl_ok;
        end else if (i_word[1]) begin
            l4_ok = is_udp && sp_ok && dp_ok;
        end else if (i_word[2]) begin
            l4_ok = is_icmp && ty_ok && co_ok;
        end else begin
            l4_ok = 1'b1;
        end

        n_nz   = r_nz;
        n_eq   = r_eq;
        o_pass = 1'b1;
        unique case (i_ctl.step)
            STEP_W5: begin
                o_pass = !(i_word[1] && (ttl < i_word[23:16])) &&
                         !(i_word[2] && (ttl > i_word[31:24])) &&
                         !(i_word[3] && (len < {1'b0, i_word[47:32]})) &&
                         !(i_word[4] && (len > {1'b0, i_word[63:48]}));
            end
            STEP_W6: o_pass = tos_ok && l4_ok;
            STEP_W0: begin
                o_pass = v6 ||
                         ((i_word[31:0] == 32'd0 || i_pkt.src_lo[31:0] == i_word[31:0]) &&
                          (i_word[63:32] == 32'd0 || i_pkt.dst_lo[31:0] == i_word[63:32]));
            end
            STEP_W1: begin
                n_nz = (i_word != '0);
                n_eq = (i_pkt.src_hi == i_word);
            end
            STEP_W2: begin
                o_pass = !v6 || !(r_nz || (i_word != '0)) ||
                         (r_eq && (i_pkt.src_lo == i_word));
            end
            STEP_W3: begin
                n_nz = (i_word != '0);
                n_eq = (i_pkt.dst_hi == i_word);
            end
            STEP_W4: begin
                o_pass = !v6 || !(r_nz || (i_word != '0)) ||
                         (r_eq && (i_pkt.dst_lo == i_word));
            end
            default: o_pass = 1'b1;
        endcase
    end

    // compare result for the high half of a v6 address is held until the low half arrives
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nz <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.valid) begin
            r_nz <= n_nz;
            r_eq <= n_eq;
        end
    end

endmodule

// ===== rtl/fmprc_checker.sv =====
// port-level checks for the packet rule classifier, bound to the top level
module fmprc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [407:0] s_axis_tdata,
    input logic         s_axis_tuser,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [15:0]  m_axis_tdata
);

    // input not ready right after reset, while the memory is being cleared
    a_reset_busy: assert property (@(posedge i_clk) !i_rst_n |=> !s_axis_tready)
        else $error("input ready right after reset");

    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser) |=> !s_axis_tready)
        else $error("ready held during a classify");

    a_unsupported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser && !m_axis_tvalid &&
         (s_axis_tdata[2:0] == 3'd0 || s_axis_tdata[2:0] == 3'd7))
        |=> ##1 (m_axis_tvalid && m_axis_tdata[1:0] == 2'b01 &&
                 m_axis_tdata[9:2] == 8'd0))
        else $error("unsupported protocol not dropped");

    a_id_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1] == (m_axis_tdata[9:2] != 8'd0)))
        else $error("matched flag and id disagree");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind first_match_packet_rule_classifier fmprc_checker u_fmprc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
